// ===== design/bitmap_slot_pool_allocator_macros.svh =====
// Assertion macros used by the checker file of the slot pool allocator.
// Depends on nothing; include with the bare file name.
`ifndef BITMAP_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bspa_pkg.sv =====
// Package of the bitmap slot pool allocator: field widths and codes.
// Depends on nothing; every other design file but the macro header imports it.
package bspa_pkg;

	localparam int ADDR_W    = 32;
	localparam int OBJ_W     = 16;
	localparam int CNT_W     = 7;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;

	// Operation codes carried in the request word.
	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_QUERY = 2'd3
	} opcode_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NOFREE  = 2'd1,
		STAT_OUTSIDE = 2'd2
	} status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE  = 2'd0,
		CFG_OBJ   = 2'd1,
		CFG_COUNT = 2'd2
	} cfg_idx_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MUL,
		S_ADDR,
		S_DIV,
		S_CHECK,
		S_FLAGS,
		S_OUT
	} state_t;

endpackage

// ===== design/bspa_intf.sv =====
// Channel interfaces of the slot pool allocator: request, response, config write.
// Depends on bspa_pkg for field widths.
interface bspa_req_if;
	import bspa_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [ADDR_W-1:0]   pointer;
	modport source (output valid, output opcode, output pointer, input ready);
	modport sink (input valid, input opcode, input pointer, output ready);
endinterface

interface bspa_rsp_if;
	import bspa_pkg::*;
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   address;
	logic [STAT_W-1:0]   status;
	logic                slot_live;
	logic                any_free;
	logic                all_free;
	modport source (output valid, output address, output status, output slot_live,
		output any_free, output all_free, input ready);
	modport sink (input valid, input address, input status, input slot_live,
		input any_free, input all_free, output ready);
endinterface

interface bspa_cfg_if;
	import bspa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bspa_div.sv =====
// Restoring bit-serial divider: 32-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on bspa_pkg for widths.
module bspa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bspa_pkg::ADDR_W-1:0]   dividend,
	input  logic [bspa_pkg::OBJ_W-1:0]    divisor,
	output logic                          done,
	output logic [bspa_pkg::ADDR_W-1:0]   quotient
);
	import bspa_pkg::*;

	localparam int CW = $clog2(ADDR_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [ADDR_W-1:0] quo_q;
	logic [OBJ_W-1:0]  rem_q;
	logic [OBJ_W-1:0]  div_q;

	logic [OBJ_W:0]    shifted;
	logic [OBJ_W:0]    diff;
	logic              ge;

	// One trial subtraction of the divisor from the shifted remainder.
	assign shifted = {rem_q, quo_q[ADDR_W-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ADDR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ADDR_W-2:0], ge};
			rem_q <= ge ? diff[OBJ_W-1:0] : shifted[OBJ_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/bitmap_slot_pool_allocator.sv =====
// Top level of the bitmap slot pool allocator: sequencer, free map and flag sweep.
// Depends on bspa_pkg, the channel interfaces in bspa_intf.sv and bspa_div.
//
// Usage: one request word (opcode, pointer) enters on req; one response word
// (address, status, slot_live, any_free, all_free) leaves on rsp for each request.
// Configuration registers (base_address, object_bytes, slot_count) are written on
// cfg, which is always ready; write them only while no request is in flight.
// Requests are handled one at a time; req is ready only while the sequencer idles.
// The free map is held in NW = ceil(MAX_SLOTS/32) words. Every request ends with a
// sweep over them for the flags; allocate first scans them for the lowest free slot,
// and free and query first turn the pointer offset into a slot index with the
// 32-step bit-serial divider, which is skipped with a zero slot size.
// The response sits in an output register, so a new request is taken while the
// previous response still waits on a stalled receiver; the sequencer waits in its
// final state only if a second response is ready before the first is taken.
// Reset empties the output register, loads the reset configuration and marks the
// first min(64, MAX_SLOTS) slots free; no clearing pass is needed.
module bitmap_slot_pool_allocator #(
	parameter int MAX_SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	bspa_req_if.sink   req,
	bspa_rsp_if.source rsp,
	bspa_cfg_if.sink   cfg
);
	import bspa_pkg::*;

	localparam int W     = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
	localparam int NW    = (MAX_SLOTS + W - 1) / W;
	localparam int PW    = NW * W;
	localparam int IW    = (PW > 1) ? $clog2(PW) : 1;
	localparam int WIW   = (NW > 1) ? $clog2(NW) : 1;
	localparam int PEW   = (W > 1) ? $clog2(W) : 1;
	localparam int NCW   = $clog2(MAX_SLOTS + 1);
	localparam int CW    = (NCW > CNT_W) ? NCW : CNT_W;
	localparam int RST_N = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
	localparam logic [PW-1:0] MAP_RST = {PW{1'b1}} >> (PW - RST_N);

	// Configuration registers.
	logic [ADDR_W-1:0] base_q;
	logic [OBJ_W-1:0]  obj_q;
	logic [CNT_W-1:0]  cnt_q;

	// Sequencer and datapath state.
	state_t            state_q, state_n;
	logic [PW-1:0]     map_q;
	logic [WIW-1:0]    wcnt_q;
	opcode_t           op_q;
	status_t           stat_q;
	logic              live_q;
	logic [ADDR_W-1:0] addr_q;
	logic              any_q;
	logic              all_q;
	logic [IW-1:0]     idx_q;
	logic [IW+OBJ_W-1:0] prod_q;

	// Output register.
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t           out_stat_q;
	logic              out_live_q;
	logic              out_any_q;
	logic              out_all_q;

	// Combinational control and datapath.
	logic              accept;
	logic              is_ptr_op;
	logic              div_start;
	logic              div_done;
	logic [ADDR_W-1:0] quotient;
	logic              out_load;
	logic [CW-1:0]     cnt_ext;
	logic [NCW-1:0]    n_eff;
	logic [PW-1:0]     use_mask;
	logic [W-1:0]      map_word;
	logic [W-1:0]      mask_word;
	logic [W-1:0]      free_word;
	logic              last_word;
	logic              found;
	logic [PEW-1:0]    pos;
	logic [IW-1:0]     alloc_idx;
	logic              idx_outside;
	logic [IW-1:0]     ptr_idx;

	// Effective slot count, clamped to the built capacity.
	assign cnt_ext = CW'(cnt_q);
	always_comb begin
		logic [CW-1:0] clamped;
		clamped = (cnt_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : cnt_ext;
		n_eff   = clamped[NCW-1:0];
	end

	// Mask of the slots in use.
	always_comb begin
		for (int i = 0; i < PW; i++) begin
			use_mask[i] = (i < int'(n_eff));
		end
	end

	// Current word of the map and of the in-use mask.
	assign map_word  = map_q[wcnt_q*W +: W];
	assign mask_word = use_mask[wcnt_q*W +: W];
	assign free_word = map_word & mask_word;
	assign last_word = (wcnt_q == WIW'(NW - 1));

	// Lowest free slot in the current word.
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int j = W - 1; j >= 0; j--) begin
			if (free_word[j]) begin
				found = 1'b1;
				pos   = PEW'(j);
			end
		end
	end
	assign alloc_idx = IW'(IW'(wcnt_q) * IW'(W)) + IW'(pos);

	// Slot index derived from the divider quotient.
	assign idx_outside = quotient >= ADDR_W'(n_eff);
	assign ptr_idx     = quotient[IW-1:0];

	assign accept    = req.valid && req.ready;
	assign is_ptr_op = (opcode_t'(req.opcode) == OP_FREE) ||
		(opcode_t'(req.opcode) == OP_QUERY);

	bspa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.pointer - base_q),
		.divisor  (obj_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Next state and control strobes.
	always_comb begin
		state_n   = state_q;
		req.ready = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (is_ptr_op && (obj_q != '0)) begin
						div_start = 1'b1;
						state_n   = S_DIV;
					end else if (opcode_t'(req.opcode) == OP_ALLOC) begin
						state_n = S_SCAN;
					end else begin
						state_n = S_FLAGS;
					end
				end
			end
			S_SCAN: begin
				if (found) begin
					state_n = S_MUL;
				end else if (last_word) begin
					state_n = S_FLAGS;
				end
			end
			S_MUL: begin
				state_n = S_ADDR;
			end
			S_ADDR: begin
				state_n = S_FLAGS;
			end
			S_DIV: begin
				if (div_done) begin
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				state_n = S_FLAGS;
			end
			S_FLAGS: begin
				if (last_word) begin
					state_n = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// State register and word counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wcnt_q  <= '0;
		end else begin
			state_q <= state_n;
			if (((state_q == S_SCAN) && !found && !last_word) ||
				((state_q == S_FLAGS) && !last_word)) begin
				wcnt_q <= wcnt_q + 1'b1;
			end else begin
				wcnt_q <= '0;
			end
		end
	end

	// Configuration writes.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			obj_q  <= OBJ_W'(16);
			cnt_q  <= CNT_W'(64);
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_BASE:  base_q <= cfg.data;
				CFG_OBJ:   obj_q  <= cfg.data[OBJ_W-1:0];
				CFG_COUNT: cnt_q  <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Free map: refill on init, clear on allocate, set on free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= MAP_RST;
		end else begin
			if (accept && (opcode_t'(req.opcode) == OP_INIT)) begin
				map_q <= use_mask;
			end else if ((state_q == S_SCAN) && found) begin
				map_q[alloc_idx] <= 1'b0;
			end else if ((state_q == S_CHECK) && !idx_outside && (op_q == OP_FREE)) begin
				map_q[ptr_idx] <= 1'b1;
			end
		end
	end

	// Per-request result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode_t'(req.opcode);
			stat_q <= (is_ptr_op && (obj_q == '0)) ? STAT_OUTSIDE : STAT_OK;
			live_q <= 1'b0;
			addr_q <= '0;
			any_q  <= 1'b0;
			all_q  <= 1'b1;
		end else begin
			unique case (state_q)
				S_SCAN: begin
					if (found) begin
						idx_q <= alloc_idx;
					end else if (last_word) begin
						stat_q <= STAT_NOFREE;
					end
				end
				S_MUL: begin
					prod_q <= (IW+OBJ_W)'(idx_q) * (IW+OBJ_W)'(obj_q);
				end
				S_ADDR: begin
					addr_q <= base_q + ADDR_W'(prod_q);
				end
				S_CHECK: begin
					if (idx_outside) begin
						stat_q <= STAT_OUTSIDE;
					end else if (op_q == OP_QUERY) begin
						live_q <= ~map_q[ptr_idx];
					end
				end
				S_FLAGS: begin
					any_q <= any_q | (|free_word);
					all_q <= all_q & (&(map_word | ~mask_word));
				end
				default: ;
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q <= addr_q;
			out_stat_q <= stat_q;
			out_live_q <= live_q;
			out_any_q  <= any_q;
			out_all_q  <= all_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.address   = out_addr_q;
	assign rsp.status    = out_stat_q;
	assign rsp.slot_live = out_live_q;
	assign rsp.any_free  = out_any_q;
	assign rsp.all_free  = out_all_q;

endmodule

// ===== design/bspa_checker.sv =====
// Port-level checker of the slot pool allocator, bound to the top level.
// Depends on bspa_pkg and bitmap_slot_pool_allocator_macros.svh.
`include "bitmap_slot_pool_allocator_macros.svh"

module bspa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [bspa_pkg::ADDR_W-1:0]   rsp_address,
	input logic [bspa_pkg::STAT_W-1:0]   rsp_status,
	input logic                          rsp_slot_live,
	input logic                          rsp_any_free
);
	import bspa_pkg::*;

	// A stalled response word holds.
	`BSPA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_address) && $stable(rsp_status), "stalled response word changed")

	// One request at a time: the request side closes after a word is taken.
	`BSPA_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while another is in flight")

	// A failed allocation means no in-use slot is free.
	`BSPA_ASSERT_SAME(a_nofree_flag, clk, arst_n, rsp_valid && (rsp_status == STAT_NOFREE), !rsp_any_free, "no free slot reported while a slot is free")

	// A live slot is only reported on a successful query.
	`BSPA_ASSERT_SAME(a_live_ok, clk, arst_n, rsp_valid && rsp_slot_live, rsp_status == STAT_OK, "slot live with a failing status")

	// A nonzero address only comes with a successful allocation.
	`BSPA_ASSERT_SAME(a_addr_ok, clk, arst_n, rsp_valid && (rsp_address != '0), rsp_status == STAT_OK, "address returned with a failing status")

endmodule

bind bitmap_slot_pool_allocator bspa_checker u_bspa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_address   (rsp.address),
	.rsp_status    (rsp.status),
	.rsp_slot_live (rsp.slot_live),
	.rsp_any_free  (rsp.any_free)
);

// ===== verif/tb.sv =====
// Testbench of the bitmap slot pool allocator: directed and random request words
// checked against a behavioral pool model kept in step with every accepted word.
// Depends on bspa_pkg, the channel interfaces in bspa_intf.sv and the top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bspa_pkg::*;

	localparam int POOL_SLOTS = 64;

	// One reply word as the pool model predicts it.
	typedef struct {
		logic [ADDR_W-1:0] address;
		status_t           status;
		logic              slot_live;
		logic              any_free;
		logic              all_free;
	} reply_t;

	logic clk;
	logic arst_n;

	bspa_req_if req_ch ();
	bspa_rsp_if rsp_ch ();
	bspa_cfg_if cfg_ch ();

	bitmap_slot_pool_allocator #(
		.MAX_SLOTS(POOL_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Model copy of the registers and the free map (1 = free).
	logic [ADDR_W-1:0]     pool_base;
	logic [OBJ_W-1:0]      pool_obj;
	logic [CNT_W-1:0]      pool_count;
	logic [POOL_SLOTS-1:0] free_bits;

	reply_t pending_replies[$];
	int     error_count = 0;
	int     req_idle_pct = 0;
	int     rsp_idle_pct = 0;

	// Free-running clock, 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Slots that count: a slot count above the capacity is clipped to it.
	function automatic int unsigned live_slots();
		return (pool_count > POOL_SLOTS) ? POOL_SLOTS : int'(pool_count);
	endfunction

	function automatic logic [POOL_SLOTS-1:0] live_mask();
		int unsigned n;
		logic [POOL_SLOTS-1:0] one_bit;
		n = live_slots();
		one_bit = POOL_SLOTS'(1);
		return (n >= POOL_SLOTS) ? '1 : ((one_bit << n) - one_bit);
	endfunction

	// Apply one request word to the pool model and return the reply it owes.
	function automatic reply_t step_pool(opcode_t op, logic [ADDR_W-1:0] ptr);
		reply_t r;
		int unsigned n;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] slot_idx;
		logic [POOL_SLOTS-1:0] mask;
		bit taken;
		n = live_slots();
		mask = live_mask();
		r.address = '0;
		r.status = STAT_OK;
		r.slot_live = 1'b0;
		taken = 1'b0;
		case (op)
			OP_INIT: free_bits = mask;
			OP_ALLOC: begin
				// Lowest free slot wins; addresses wrap at 32 bits.
				r.status = STAT_NOFREE;
				for (int i = 0; i < n; i++) begin
					if (!taken && free_bits[i]) begin
						free_bits[i] = 1'b0;
						r.address = pool_base + ADDR_W'(i) * ADDR_W'(pool_obj);
						r.status = STAT_OK;
						taken = 1'b1;
					end
				end
			end
			default: begin
				// Free and query: truncating division of the wrapped offset.
				offset = ptr - pool_base;
				if (pool_obj == '0) begin
					r.status = STAT_OUTSIDE;
				end else begin
					slot_idx = offset / ADDR_W'(pool_obj);
					if (slot_idx >= n)
						r.status = STAT_OUTSIDE;
					else if (op == OP_FREE)
						free_bits[slot_idx] = 1'b1;
					else
						r.slot_live = !free_bits[slot_idx];
				end
			end
		endcase
		r.any_free = |(free_bits & mask);
		r.all_free = ((free_bits & mask) == mask);
		return r;
	endfunction

	// A pointer somewhere inside slot idx of the current chunk.
	function automatic logic [ADDR_W-1:0] slot_pointer(int unsigned idx);
		logic [ADDR_W-1:0] inner;
		inner = (pool_obj == '0) ? '0 : ADDR_W'($urandom_range(pool_obj - 1));
		return pool_base + ADDR_W'(idx) * ADDR_W'(pool_obj) + inner;
	endfunction

	function automatic void check_field(string name, logic [ADDR_W-1:0] want,
		logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endfunction

	// Send one request word, idling first at random; valid is left high.
	task automatic send_request(opcode_t op, logic [ADDR_W-1:0] ptr);
		@(negedge clk);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.opcode = op;
		req_ch.pointer = ptr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_replies.push_back(step_pool(op, ptr));
	endtask

	// Stop sending and wait until every reply word has come back.
	task automatic wait_for_replies();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_BASE: pool_base = value;
			CFG_OBJ: pool_obj = value[OBJ_W-1:0];
			CFG_COUNT: pool_count = value[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_pool(logic [ADDR_W-1:0] base, logic [OBJ_W-1:0] obj,
		logic [CNT_W-1:0] count);
		write_register(CFG_BASE, base);
		write_register(CFG_OBJ, ADDR_W'(obj));
		write_register(CFG_COUNT, ADDR_W'(count));
	endtask

	// Allocate, free and query under the reset configuration, including a double free.
	task automatic test_basic_ops();
		send_request(OP_QUERY, 32'h0);
		send_request(OP_ALLOC, 32'hFFFF_FFFF);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_QUERY, 32'd31);
		send_request(OP_FREE, 32'd16);
		send_request(OP_FREE, 32'd16);
		send_request(OP_QUERY, 32'd1024);
		send_request(OP_QUERY, 32'hFFFF_FFFF);
		wait_for_replies();
	endtask

	// A three-slot pool that straddles the top of the address space.
	task automatic test_small_pool_wrap();
		set_pool(32'hFFFF_FFFE, 16'd1, 7'd3);
		send_request(OP_INIT, 32'h0);
		repeat (4)
			send_request(OP_ALLOC, 32'h0);
		send_request(OP_FREE, 32'hFFFF_FFFF);
		send_request(OP_QUERY, 32'hFFFF_FFFD);
		wait_for_replies();
	endtask

	// Zero slots, zero slot size and a slot count above the capacity.
	task automatic test_degenerate_sizes();
		set_pool(32'h0000_1000, 16'd16, 7'd0);
		send_request(OP_INIT, 32'h0);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_QUERY, 32'h0000_1000);
		wait_for_replies();
		set_pool(32'h8000_0000, 16'd0, 7'd5);
		send_request(OP_INIT, 32'h0);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_FREE, 32'h8000_0000);
		wait_for_replies();
		set_pool(32'h0, 16'hFFFF, 7'd127);
		send_request(OP_INIT, 32'h0);
		send_request(OP_ALLOC, 32'h0);
		wait_for_replies();
	endtask

	// Shrink and regrow the slot count without an init between.
	task automatic test_shrink_without_init();
		set_pool(32'hFFFF_0000, 16'hFFFF, 7'd64);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_ALLOC, 32'h0);
		wait_for_replies();
		write_register(CFG_COUNT, 32'd1);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_QUERY, slot_pointer(1));
		wait_for_replies();
		write_register(CFG_COUNT, 32'd64);
		send_request(OP_QUERY, slot_pointer(1));
		wait_for_replies();
	endtask

	// Mostly allocate, free and query of real slots, with some noise words.
	task automatic send_random_request();
		int unsigned pick;
		int unsigned n;
		int unsigned idx;
		n = live_slots();
		pick = $urandom_range(99);
		idx = (n == 0) ? 0 : $urandom_range(n - 1);
		if (pick < 3)
			send_request(OP_INIT, $urandom);
		else if (pick < 43)
			send_request(OP_ALLOC, $urandom);
		else if (pick < 68)
			send_request(OP_FREE, slot_pointer(idx));
		else if (pick < 88)
			send_request(OP_QUERY, slot_pointer(idx));
		else if (pick < 94)
			send_request(opcode_t'($urandom_range(3)), $urandom);
		else
			send_request($urandom_range(1) ? OP_FREE : OP_QUERY,
				$urandom_range(1) ? slot_pointer(n) : pool_base - 1);
	endtask

	// Random rounds, each under a fresh configuration, with the idle mix changing.
	task automatic test_random_traffic(int unsigned rounds, int unsigned per_round);
		logic [ADDR_W-1:0] base;
		logic [OBJ_W-1:0] obj;
		logic [CNT_W-1:0] count;
		for (int unsigned r = 0; r < rounds; r++) begin
			case (r * 3 / rounds)
				0: begin
					req_idle_pct = 28;
					rsp_idle_pct = 46;
				end
				1: begin
					req_idle_pct = 46;
					rsp_idle_pct = 28;
				end
				default: begin
					req_idle_pct = 0;
					rsp_idle_pct = 0;
				end
			endcase
			case ($urandom_range(3))
				0: base = '0;
				1: base = '1;
				default: base = $urandom;
			endcase
			case ($urandom_range(19))
				0: obj = '0;
				1: obj = '1;
				2: obj = 16'd1;
				3: obj = OBJ_W'($urandom_range(1, 65535));
				default: obj = OBJ_W'($urandom_range(1, 64));
			endcase
			case ($urandom_range(19))
				0: count = '0;
				1: count = '1;
				2: count = CNT_W'($urandom_range(65, 126));
				3: count = 7'd64;
				4: count = 7'd1;
				default: count = CNT_W'($urandom_range(2, 63));
			endcase
			set_pool(base, obj, count);
			// Now and then keep the old map across the new configuration.
			if ($urandom_range(9) != 0)
				send_request(OP_INIT, $urandom);
			repeat (per_round)
				send_random_request();
			wait_for_replies();
		end
	endtask

	// Receiver side: random stalls on the reply channel.
	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= rsp_idle_pct);
	end

	// Compare each accepted reply word with the oldest prediction.
	always @(posedge clk) begin : reply_checker
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_replies.size() == 0) begin
				$error("reply word with no request outstanding: address %0h status %0d",
					rsp_ch.address, rsp_ch.status);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				check_field("address", want.address, rsp_ch.address);
				check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_ch.status));
				check_field("slot_live", ADDR_W'(want.slot_live), ADDR_W'(rsp_ch.slot_live));
				check_field("any_free", ADDR_W'(want.any_free), ADDR_W'(rsp_ch.any_free));
				check_field("all_free", ADDR_W'(want.all_free), ADDR_W'(rsp_ch.all_free));
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_INIT;
		req_ch.pointer = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_BASE;
		cfg_ch.data = '0;
		pool_base = '0;
		pool_obj = 16'd16;
		pool_count = 7'd64;
		free_bits = '1;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		req_idle_pct = 28;
		rsp_idle_pct = 46;
		test_basic_ops();
		test_small_pool_wrap();
		test_degenerate_sizes();
		test_shrink_without_init();
		test_random_traffic(12, 120);

		wait_for_replies();
		repeat (64)
			@(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/bspa_pkg.sv
design/bspa_intf.sv
design/bspa_div.sv
design/bitmap_slot_pool_allocator.sv
design/bspa_checker.sv
verif/tb.sv
